### rtl/aesc_pkg.sv
// ============================================================================
// aesc_pkg
// Shared types and constants for the escape sequence stripper.
// ============================================================================
package aesc_pkg;

    // Hold buffer geometry.
    localparam int HOLD_DEPTH = 32;
    localparam int HOLD_AW    = $clog2(HOLD_DEPTH);
    localparam int HOLD_CW    = $clog2(HOLD_DEPTH + 1);

    // Command queue between the front and back parts.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Character codes used by the parser.
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Visible count saturates at this value.
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // One input item.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       text_end;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        has_byte;
        logic        end_of_run;
        logic [15:0] visible_count;
    } t_out_item;

    // Command passed from the front part to the back part.
    typedef struct packed {
        logic [7:0] cmd_byte;
        logic       has_byte;
        logic       last;
    } t_cmd;

endpackage

### rtl/aesc_ram.sv
// ============================================================================
// aesc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
module aesc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/aesc_queue.sv
// ============================================================================
// aesc_queue
// Short command queue that decouples the parser from the output stage.
// ============================================================================
module aesc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  aesc_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output aesc_pkg::t_cmd o_cmd,
    output logic          o_empty
);

    aesc_pkg::t_cmd r_slot [aesc_pkg::Q_DEPTH];
    logic [aesc_pkg::Q_AW-1:0] r_wr_ptr;
    logic [aesc_pkg::Q_AW-1:0] r_rd_ptr;
    logic [aesc_pkg::Q_CW-1:0] r_count;
    logic                      do_push;
    logic                      do_pop;

    assign o_full  = (r_count == aesc_pkg::Q_CW'(aesc_pkg::Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_slot[r_rd_ptr];

    // Pointer and occupancy tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage slots.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### rtl/aesc_front.sv
// ============================================================================
// aesc_front
// Parser: accepts bytes, holds possible escape sequences, and issues output
// commands, replaying held bytes when a sequence turns out invalid.
// ============================================================================
module aesc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  aesc_pkg::t_in_item i_item,
    output logic              o_full,
    output logic              o_q_push,
    output aesc_pkg::t_cmd     o_q_cmd,
    input  logic              i_q_full
);

    typedef enum logic [1:0] {
        S_ACCEPT,
        S_REPLAY,
        S_TAIL
    } t_seq;

    typedef enum logic [1:0] {
        M_IDLE,
        M_ESC,
        M_CSI
    } t_mode;

    t_seq                         r_seq,       n_seq;
    t_mode                        r_mode,      n_mode;
    logic [aesc_pkg::HOLD_CW-1:0] r_held,      n_held;
    logic [aesc_pkg::HOLD_CW-1:0] r_idx,       n_idx;
    logic [aesc_pkg::HOLD_CW-1:0] r_rep_n,     n_rep_n;
    logic [7:0]                   r_tail_byte, n_tail_byte;
    logic                         r_tail_en,   n_tail_en;
    logic                         r_last,      n_last;

    logic                         ram_we;
    logic                         ram_re;
    logic [aesc_pkg::HOLD_AW-1:0] ram_raddr;
    logic [7:0]                   ram_rdata;
    logic [aesc_pkg::HOLD_CW-1:0] idx_inc;

    logic [7:0] b;
    logic       last;
    logic       accept;
    logic       is_esc;
    logic       is_body;
    logic       is_final;
    logic       room;
    logic       cont;
    logic       drop;
    logic       hold_esc;
    logic       rep_last;
    logic [7:0] rep_byte;

    assign b       = i_item.data_byte;
    assign last    = i_item.text_end;
    assign o_full  = (r_seq != S_ACCEPT) || i_q_full;
    assign accept  = i_push && !o_full;
    assign idx_inc = r_idx + 1'b1;

    // Byte classification.
    assign is_esc   = (b == aesc_pkg::CH_ESC);
    assign is_body  = ((b >= aesc_pkg::CH_ZERO) && (b <= aesc_pkg::CH_NINE))
                      || (b == aesc_pkg::CH_SEMI);
    assign is_final = (b >= aesc_pkg::CH_AT) && (b <= aesc_pkg::CH_TILDE);
    assign room     = (r_held < aesc_pkg::HOLD_CW'(aesc_pkg::HOLD_DEPTH));

    // A sequence goes on, is dropped as complete, or breaks.
    always_comb begin
        cont = 1'b0;
        drop = 1'b0;
        unique case (r_mode)
            M_ESC: begin
                cont = (b == aesc_pkg::CH_LBRACK);
                drop = (b == aesc_pkg::CH_M);
            end
            M_CSI: begin
                cont = is_body && room;
                drop = !is_body && is_final;
            end
            default: begin
                cont = 1'b0;
                drop = 1'b0;
            end
        endcase
    end

    // A breaking ESC that does not end the text starts a new sequence.
    assign hold_esc = !cont && !drop && is_esc && !last;

    // The first two held bytes are always ESC and '['; the rest come from RAM.
    always_comb begin
        if (r_idx == '0) begin
            rep_byte = aesc_pkg::CH_ESC;
        end else if (r_idx == aesc_pkg::HOLD_CW'(1)) begin
            rep_byte = aesc_pkg::CH_LBRACK;
        end else begin
            rep_byte = ram_rdata;
        end
    end

    assign rep_last = (idx_inc == r_rep_n);

    // Next-state and command issue logic.
    always_comb begin
        n_seq       = r_seq;
        n_mode      = r_mode;
        n_held      = r_held;
        n_idx       = r_idx;
        n_rep_n     = r_rep_n;
        n_tail_byte = r_tail_byte;
        n_tail_en   = r_tail_en;
        n_last      = r_last;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = '0;
        o_q_push    = 1'b0;
        o_q_cmd     = '0;

        unique case (r_seq)
            S_ACCEPT: begin
                if (accept) begin
                    if (r_mode == M_IDLE) begin
                        if (is_esc && !last) begin
                            n_mode = M_ESC;
                            n_held = aesc_pkg::HOLD_CW'(1);
                        end else begin
                            o_q_push = 1'b1;
                            o_q_cmd  = '{cmd_byte: b, has_byte: 1'b1, last: last};
                        end
                    end else if (drop) begin
                        n_mode = M_IDLE;
                        n_held = '0;
                        if (last) begin
                            o_q_push = 1'b1;
                            o_q_cmd  = '{cmd_byte: 8'h00, has_byte: 1'b0, last: 1'b1};
                        end
                    end else if (cont && !last) begin
                        if (r_mode == M_ESC) begin
                            n_mode = M_CSI;
                            n_held = aesc_pkg::HOLD_CW'(2);
                        end else begin
                            ram_we = 1'b1;
                            n_held = r_held + 1'b1;
                        end
                    end else begin
                        // Replay the held bytes, then handle this byte from idle.
                        ram_re      = 1'b1;
                        n_seq       = S_REPLAY;
                        n_idx       = '0;
                        n_rep_n     = r_held;
                        n_tail_byte = b;
                        n_tail_en   = !hold_esc;
                        n_last      = last;
                        n_mode      = hold_esc ? M_ESC : M_IDLE;
                        n_held      = hold_esc ? aesc_pkg::HOLD_CW'(1) : '0;
                    end
                end
            end
            S_REPLAY: begin
                if (!i_q_full) begin
                    o_q_push = 1'b1;
                    o_q_cmd  = '{cmd_byte: rep_byte, has_byte: 1'b1,
                                 last: r_last && !r_tail_en && rep_last};
                    if (rep_last) begin
                        n_seq = r_tail_en ? S_TAIL : S_ACCEPT;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = idx_inc[aesc_pkg::HOLD_AW-1:0];
                        n_idx     = idx_inc;
                    end
                end
            end
            S_TAIL: begin
                if (!i_q_full) begin
                    o_q_push = 1'b1;
                    o_q_cmd  = '{cmd_byte: r_tail_byte, has_byte: 1'b1, last: r_last};
                    n_seq    = S_ACCEPT;
                end
            end
            default: begin
                n_seq = S_ACCEPT;
            end
        endcase
    end

    // State and registered control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq     <= S_ACCEPT;
            r_mode    <= M_IDLE;
            r_held    <= '0;
            r_idx     <= '0;
            r_rep_n   <= '0;
            r_tail_en <= 1'b0;
            r_last    <= 1'b0;
        end else begin
            r_seq     <= n_seq;
            r_mode    <= n_mode;
            r_held    <= n_held;
            r_idx     <= n_idx;
            r_rep_n   <= n_rep_n;
            r_tail_en <= n_tail_en;
            r_last    <= n_last;
        end
        r_tail_byte <= n_tail_byte;
    end

    // Hold buffer for sequence body bytes.
    aesc_ram #(
        .WIDTH (8),
        .DEPTH (aesc_pkg::HOLD_DEPTH)
    ) u_hold_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_held[aesc_pkg::HOLD_AW-1:0]),
        .i_wdata (b),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

### rtl/aesc_back.sv
// ============================================================================
// aesc_back
// Output stage: counts visible bytes and presents result items.
// ============================================================================
module aesc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  aesc_pkg::t_cmd      i_q_cmd,
    output logic               o_q_pop,
    output logic               o_empty,
    output aesc_pkg::t_out_item o_item,
    input  logic               i_pop
);

    logic                r_valid;
    logic [15:0]         r_total;
    aesc_pkg::t_out_item r_item;
    logic                load;
    logic [15:0]         n_count;

    assign load    = !i_q_empty && (!r_valid || i_pop);
    assign o_q_pop = load;
    assign o_empty = !r_valid;
    assign o_item  = r_item;

    // Saturating visible count including this item.
    assign n_count = (i_q_cmd.has_byte && (r_total != aesc_pkg::COUNT_MAX))
                     ? r_total + 16'd1 : r_total;

    // Output register and running total.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_total <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_total <= i_q_cmd.last ? 16'd0 : n_count;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
        if (load) begin
            r_item <= '{out_byte: i_q_cmd.cmd_byte, has_byte: i_q_cmd.has_byte,
                        end_of_run: i_q_cmd.last, visible_count: n_count};
        end
    end

endmodule

### rtl/ansi_escape_stripper_core.sv
// ============================================================================
// ansi_escape_stripper_core
// Path: a visible byte goes via the command queue into the output register.
// Throughput: one byte per cycle while the queue has room and no replay runs;
// a broken sequence holds the input full while its held bytes and a visible breaking byte go out.
// Reset: synchronous, active low; clears parser, queue and count. The hold
// RAM is not cleared and needs no clearing pass.
// ============================================================================
module ansi_escape_stripper_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  aesc_pkg::t_in_item  i_in_item,
    output logic               full,
    output logic               empty,
    output aesc_pkg::t_out_item o_out_item,
    input  logic               pop
);

    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_empty;
    aesc_pkg::t_cmd q_in_cmd;
    aesc_pkg::t_cmd q_out_cmd;

    // Parser and replay sequencer.
    aesc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (i_in_item),
        .o_full   (full),
        .o_q_push (q_push),
        .o_q_cmd  (q_in_cmd),
        .i_q_full (q_full)
    );

    // Command queue.
    aesc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (q_out_cmd),
        .o_empty (q_empty)
    );

    // Counting and output stage.
    aesc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_cmd   (q_out_cmd),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .o_item    (o_out_item),
        .i_pop     (pop)
    );

endmodule

### test/ansi_escape_stripper_checker.sv
// ============================================================================
// ansi_escape_stripper_checker
// Watches both queue interfaces of the escape stripper. It predicts the
// visible bytes, end markers and running counts for every accepted item and
// compares each popped result with the oldest prediction, field by field.
// ============================================================================
`timescale 1ns / 1ps

module ansi_escape_stripper_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic                i_full,
    input  aesc_pkg::t_in_item  i_in_item,
    input  logic                i_empty,
    input  logic                i_pop,
    input  aesc_pkg::t_out_item i_out_item,
    output int                  o_fail_count,
    output int                  o_pending
);
    import aesc_pkg::*;

    typedef enum logic [1:0] {
        PARSE_IDLE,
        PARSE_ESC,
        PARSE_CSI
    } t_parse_mode;

    // Shadow copy of the parser state.
    t_parse_mode parse_state;
    logic [7:0]  seq_bytes [HOLD_DEPTH];
    int          seq_len;
    logic [15:0] shown_total;

    // Predicted results in output order.
    t_out_item   stripped_q [$];
    int          popped_count;

    task automatic report_mismatch(input string what);
        $display("[%0t] ERROR result %0d: %s", $time, popped_count, what);
        o_fail_count++;
    endtask

    function automatic void emit_visible(input logic [7:0] b);
        t_out_item r;
        if (shown_total != COUNT_MAX) begin
            shown_total++;
        end
        r.out_byte      = b;
        r.has_byte      = 1'b1;
        r.end_of_run    = 1'b0;
        r.visible_count = shown_total;
        stripped_q.push_back(r);
    endfunction

    // A broken sequence comes out as plain text, in arrival order.
    function automatic void replay_held();
        for (int i = 0; i < seq_len; i++) begin
            emit_visible(seq_bytes[i]);
        end
        seq_len     = 0;
        parse_state = PARSE_IDLE;
    endfunction

    function automatic void start_from_idle(input logic [7:0] b);
        if (b == CH_ESC) begin
            seq_bytes[0] = b;
            seq_len      = 1;
            parse_state  = PARSE_ESC;
        end else begin
            emit_visible(b);
        end
    endfunction

    function automatic void predict_item(input t_in_item item);
        logic [7:0] b;
        logic       is_param;
        int         n_before;
        t_out_item  tail;
        b        = item.data_byte;
        is_param = ((b >= CH_ZERO) && (b <= CH_NINE)) || (b == CH_SEMI);
        n_before = stripped_q.size();

        case (parse_state)
            PARSE_ESC: begin
                if (b == CH_LBRACK) begin
                    seq_bytes[1] = b;
                    seq_len      = 2;
                    parse_state  = PARSE_CSI;
                end else if (b == CH_M) begin
                    seq_len     = 0;
                    parse_state = PARSE_IDLE;
                end else begin
                    replay_held();
                    start_from_idle(b);
                end
            end
            PARSE_CSI: begin
                // A parameter byte that finds the hold full breaks the sequence.
                if (is_param && (seq_len < HOLD_DEPTH)) begin
                    seq_bytes[seq_len] = b;
                    seq_len++;
                end else if (!is_param && (b >= CH_AT) && (b <= CH_TILDE)) begin
                    seq_len     = 0;
                    parse_state = PARSE_IDLE;
                end else begin
                    replay_held();
                    start_from_idle(b);
                end
            end
            default: begin
                start_from_idle(b);
            end
        endcase

        // End of text: flush any open sequence and mark the last result.
        if (item.text_end) begin
            if (parse_state != PARSE_IDLE) begin
                replay_held();
            end
            if (stripped_q.size() == n_before) begin
                tail.out_byte      = 8'h00;
                tail.has_byte      = 1'b0;
                tail.end_of_run    = 1'b0;
                tail.visible_count = shown_total;
                stripped_q.push_back(tail);
            end
            tail            = stripped_q.pop_back();
            tail.end_of_run = 1'b1;
            stripped_q.push_back(tail);
            shown_total = '0;
            seq_len     = 0;
            parse_state = PARSE_IDLE;
        end
    endfunction

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (stripped_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result byte=%02h has=%0b end=%0b cnt=%0d",
                got.out_byte, got.has_byte, got.end_of_run, got.visible_count));
        end else begin
            want = stripped_q.pop_front();
            if (got.out_byte !== want.out_byte) begin
                report_mismatch($sformatf("out_byte %02h, expected %02h",
                    got.out_byte, want.out_byte));
            end
            if (got.has_byte !== want.has_byte) begin
                report_mismatch($sformatf("has_byte %0b, expected %0b",
                    got.has_byte, want.has_byte));
            end
            if (got.end_of_run !== want.end_of_run) begin
                report_mismatch($sformatf("end_of_run %0b, expected %0b",
                    got.end_of_run, want.end_of_run));
            end
            if (got.visible_count !== want.visible_count) begin
                report_mismatch($sformatf("visible_count %0d, expected %0d",
                    got.visible_count, want.visible_count));
            end
        end
        popped_count++;
    endtask

    // Both handshakes are sampled at the rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            parse_state = PARSE_IDLE;
            seq_len     = 0;
            shown_total = '0;
            stripped_q.delete();
        end else begin
            if (i_push && !i_full) begin
                predict_item(i_in_item);
            end
            if (i_pop && !i_empty) begin
                check_result(i_out_item);
            end
        end
        o_pending = stripped_q.size();
    end

endmodule

### test/ansi_escape_stripper_core_tb.sv
// ============================================================================
// ansi_escape_stripper_core_tb
// Drives byte streams into the escape stripper: a directed set of sequences,
// then random texts mixing plain bytes, complete, broken and truncated escape
// sequences, with a back-pressure phase and a drain pause.
// ============================================================================
`timescale 1ns / 1ps

module ansi_escape_stripper_core_tb;
    import aesc_pkg::*;

    localparam int ITEM_TARGET     = 350;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int CYCLE_LIMIT     = 100000;
    localparam int IDLE_PERCENT    = 34;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push    = 1'b0;
    logic      pop     = 1'b0;
    t_in_item  in_item = '0;
    logic      full;
    logic      empty;
    t_out_item out_item;

    int        fail_count;
    int        pending;
    int        items_sent  = 0;
    int        cycle_count = 0;
    bit        idle_on     = 1'b1;
    bit        hold_req    = 1'b0;
    logic [7:0] text_bytes [$];

    always #6 i_clk = ~i_clk;

    ansi_escape_stripper_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .i_in_item  (in_item),
        .full       (full),
        .empty      (empty),
        .o_out_item (out_item),
        .pop        (pop)
    );

    ansi_escape_stripper_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_in_item    (in_item),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Offer one item; returns right after the edge that accepts it.
    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge i_clk);
        while (idle_on && ($urandom_range(99) < IDLE_PERCENT)) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push    <= 1'b1;
        in_item <= '{data_byte: b, text_end: last};
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        push <= 1'b0;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_bytes.size(); i++) begin
            send_byte(text_bytes[i], i == text_bytes.size() - 1);
        end
    endtask

    function automatic logic [7:0] param_byte();
        int r;
        r = $urandom_range(10);
        return (r == 10) ? CH_SEMI : CH_ZERO + 8'(r);
    endfunction

    // One text built from random parts, mostly well-formed sequences.
    task automatic build_text(input int n_parts);
        int kind;
        int len;
        text_bytes.delete();
        for (int p = 0; p < n_parts; p++) begin
            kind = $urandom_range(99);
            if (kind < 35) begin
                text_bytes.push_back(8'($urandom_range(255)));
            end else if ((kind < 60) || ((kind >= 80) && (kind < 95))) begin
                // CSI with a short body, now and then one long enough to overflow.
                text_bytes.push_back(CH_ESC);
                text_bytes.push_back(CH_LBRACK);
                len = ($urandom_range(7) == 0) ? $urandom_range(29, 33) : $urandom_range(5);
                repeat (len) text_bytes.push_back(param_byte());
                if (kind < 60) begin
                    text_bytes.push_back(8'($urandom_range(CH_AT, CH_TILDE)));
                end else begin
                    text_bytes.push_back(8'($urandom_range(255)));
                end
            end else if (kind < 70) begin
                text_bytes.push_back(CH_ESC);
                text_bytes.push_back(CH_M);
            end else if (kind < 80) begin
                text_bytes.push_back(CH_ESC);
                text_bytes.push_back(8'($urandom_range(255)));
            end else begin
                // Stray parameter bytes outside any sequence.
                repeat ($urandom_range(1, 4)) text_bytes.push_back(param_byte());
            end
        end
        // Sometimes the text stops inside an open sequence.
        if ($urandom_range(4) == 0) begin
            text_bytes.push_back(CH_ESC);
            if ($urandom_range(1) == 1) begin
                text_bytes.push_back(CH_LBRACK);
                repeat ($urandom_range(3)) text_bytes.push_back(param_byte());
            end
        end
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
            end else begin
                pop <= !(idle_on && ($urandom_range(99) < IDLE_PERCENT));
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int random_start;
        int text_idx;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: byte extremes, complete CSI, ESC M, broken sequences.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_ESC, 1'b0);
        send_byte(CH_LBRACK, 1'b0);
        send_byte(CH_ZERO + 8'd1, 1'b0);
        send_byte(CH_SEMI, 1'b0);
        send_byte(CH_NINE, 1'b0);
        send_byte(8'h6D, 1'b0);
        send_byte(CH_ESC, 1'b0);
        send_byte(CH_M, 1'b0);
        // A second ESC breaks the first and opens a CSI ended by '@'.
        send_byte(CH_ESC, 1'b0);
        send_byte(CH_ESC, 1'b0);
        send_byte(CH_LBRACK, 1'b0);
        send_byte(CH_AT, 1'b0);
        send_byte(CH_ESC, 1'b0);
        send_byte(CH_LBRACK, 1'b0);
        send_byte(CH_ZERO, 1'b0);
        send_byte(CH_TILDE, 1'b0);
        // CSI broken by a non-final byte that also ends the text.
        send_byte(CH_ESC, 1'b0);
        send_byte(CH_LBRACK, 1'b0);
        send_byte(CH_ZERO + 8'd3, 1'b0);
        send_byte(8'h7F, 1'b1);
        // Text ends inside an open CSI.
        send_byte(CH_ESC, 1'b0);
        send_byte(CH_LBRACK, 1'b0);
        send_byte(CH_ZERO + 8'd5, 1'b1);
        // Text with nothing visible gives a bare end marker.
        send_byte(CH_ESC, 1'b0);
        send_byte(CH_M, 1'b1);
        // Hold overflow: one parameter byte more than the hold can take.
        send_byte(CH_ESC, 1'b0);
        send_byte(CH_LBRACK, 1'b0);
        for (int i = 0; i < HOLD_DEPTH - 1; i++) begin
            send_byte(param_byte(), i == HOLD_DEPTH - 2);
        end

        // Random texts.
        random_start = items_sent;
        text_idx     = 0;
        while (items_sent - random_start < ITEM_TARGET) begin
            text_idx++;
            idle_on = !((text_idx >= 20) && (text_idx < 32));
            if (text_idx == 6) begin
                // Receiver stalls while a long text keeps coming.
                hold_req = 1'b1;
                text_bytes.delete();
                repeat (48) text_bytes.push_back(8'($urandom_range(255)));
                send_text();
            end
            if (text_idx == 14) begin
                stop_sending();
                wait (pending == 0);
            end
            build_text($urandom_range(1, 8));
            send_text();
        end
        idle_on = 1'b1;

        stop_sending();
        wait (pending == 0);
        repeat (16) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
